FILE: rtl/core/pcdd_pkg.sv
`default_nettype none

package pcdd_pkg;

    // Fixed field widths.
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned WEIGHT_W   = 9;
    localparam int unsigned COST_W     = 16;
    localparam int unsigned PAIRS_W    = 11;

    // Arithmetic constants.
    localparam int unsigned FULL_WEIGHT   = 256;
    localparam int unsigned WEIGHT_RESET  = 51;
    localparam int unsigned CHAN_SQ_MAX   = 65025;
    localparam int unsigned COLOR_NORM    = 3 * CHAN_SQ_MAX;
    localparam int unsigned MAX_PAIRS_DEF = 1024;

    // The weight scale of 256 and the sixteen fraction bits of the cost.
    localparam int unsigned SCALE_SH = 8;
    localparam int unsigned FRAC_W   = 16;
    // Quotient bits: the cost can reach exactly 1.0 before saturation.
    localparam int unsigned QUO_W    = FRAC_W + 1;
    // Second multiplier operand: holds a byte difference, the colour weight 256-w, or three times the depth weight.
    localparam int unsigned MULB_W   = 10;

    // Channel codes used while squaring the differences.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_DEPTH = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] first_red;
        logic [PIX_W-1:0] first_green;
        logic [PIX_W-1:0] first_blue;
        logic [PIX_W-1:0] first_depth;
        logic [PIX_W-1:0] second_red;
        logic [PIX_W-1:0] second_green;
        logic [PIX_W-1:0] second_blue;
        logic [PIX_W-1:0] second_depth;
        logic             pair_valid;
        logic             last_pair;
    } t_pair;

    typedef struct packed {
        logic [COST_W-1:0]  patch_cost;
        logic [PAIRS_W-1:0] pairs_counted;
        logic               no_valid_pairs;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/patch_color_depth_distance.sv
`default_nettype none

// Patch distance engine. Pixel pairs of two patches arrive as transactions on the
// input channel; every pair flagged valid (up to MAX_PAIRS per patch) adds its squared
// red, green and blue differences to a colour sum and its squared depth difference to
// a depth sum. The pair flagged last closes the patch: the block then delivers one
// result transaction holding the cost
//   ((256-w)/256 * colour_sum/(3*65025) + w/256 * depth_sum/65025) / count
// as a truncated Q0.16 fraction saturated at 65535, the number of pairs counted, and
// an empty flag (cost 0) when no pair was valid. Afterwards all sums are cleared.
// The depth weight w is written through i_cfg_we/i_cfg_data in 1/256 units, resets to
// 51, and values above 256 act as 256; write it only while the block is idle.
// One arithmetic unit, a single multiplier, is shared under a small sequencer, and
// the block takes one transaction at a time. A pair that does not count is only
// accepted. A pair that counts is accepted, then the multiplier squares the red, green,
// blue and depth differences in turn, and a final accumulate follows. A last pair then
// passes, when pairs were counted, through two weight products, a sum, a restoring
// divider producing one quotient bit per cycle and the result load, or straight to the
// load when none were; the load waits while an earlier result is still unread.

module patch_color_depth_distance #(
    parameter int unsigned MAX_PAIRS = pcdd_pkg::MAX_PAIRS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output      logic                              o_in_ready,
    input  wire pcdd_pkg::t_pair                   i_in_data,
    output      logic                              o_out_valid,
    input  wire logic                              i_out_ready,
    output      pcdd_pkg::t_result                 o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcdd_pkg::WEIGHT_W-1:0]     i_cfg_data
);

    // Widths of the running sums follow from the largest patch.
    localparam int unsigned     CNT_W     = $clog2(MAX_PAIRS + 1);
    localparam longint unsigned COLOR_MAX = longint'(pcdd_pkg::COLOR_NORM) *
                                            longint'(MAX_PAIRS);
    localparam longint unsigned DEPTH_MAX = longint'(pcdd_pkg::CHAN_SQ_MAX) *
                                            longint'(MAX_PAIRS);
    localparam int unsigned     SUMC_W    = $clog2(COLOR_MAX + 1);
    localparam int unsigned     SUMD_W    = $clog2(DEPTH_MAX + 1);
    localparam int unsigned     PROD_W    = SUMC_W + pcdd_pkg::MULB_W;
    // The weighted numerator is bounded by 256 times the largest colour sum.
    localparam int unsigned     NUMP_W    = SUMC_W + pcdd_pkg::SCALE_SH;
    localparam int unsigned     NUM_W     = NUMP_W + pcdd_pkg::SCALE_SH;
    localparam int unsigned     STEP_W    = $clog2(pcdd_pkg::QUO_W);
    localparam int unsigned     W         = pcdd_pkg::WEIGHT_W;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SQ   = 9'b000000010,
        ST_ACC  = 9'b000000100,
        ST_FIN  = 9'b000001000,
        ST_WC   = 9'b000010000,
        ST_WD   = 9'b000100000,
        ST_NUM  = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_EMIT = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Control state, set by reset: the weight to its reset value, the rest to zero.
    logic [W-1:0]      r_weight;
    logic [CNT_W-1:0]  r_count;
    logic [SUMC_W-1:0] r_color;
    logic [SUMD_W-1:0] r_depth;
    logic [SUMC_W-1:0] r_den;        // 3*65025 times the pair count, built by addition
    logic              r_acc_en;
    logic              r_out_valid;

    // Datapath registers.
    pcdd_pkg::t_pair   r_pair;
    logic              r_last;
    logic [1:0]        r_ch;
    logic [1:0]        r_acc_ch;
    logic [PROD_W-1:0] r_prod;
    logic [NUMP_W-1:0] r_num;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dsor;
    logic [pcdd_pkg::QUO_W-1:0] r_quo;
    logic [STEP_W-1:0] r_step;
    pcdd_pkg::t_result r_out_data;

    logic              in_acc;
    logic              takes;
    logic              out_free;
    logic              emit_fire;
    logic [W-1:0]      w_sat;
    logic [pcdd_pkg::PIX_W-1:0] pix_a, pix_b, abs_diff;
    logic [SUMC_W-1:0] mul_a;
    logic [pcdd_pkg::MULB_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [NUM_W:0]    div_sub;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    // A pair enters the sums only while the patch still has room.
    assign takes       = i_in_data.pair_valid && (r_count < CNT_W'(MAX_PAIRS));
    assign out_free    = !r_out_valid || i_out_ready;
    assign emit_fire   = (r_state == ST_EMIT) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Weights above full scale behave as full scale, leaving depth alone.
    assign w_sat = (r_weight > W'(pcdd_pkg::FULL_WEIGHT)) ? W'(pcdd_pkg::FULL_WEIGHT)
                                                         : r_weight;

    // Select the channel that the multiplier squares in this cycle.
    always_comb begin
        case (r_ch)
            pcdd_pkg::CH_RED: begin
                pix_a = r_pair.first_red;
                pix_b = r_pair.second_red;
            end
            pcdd_pkg::CH_GREEN: begin
                pix_a = r_pair.first_green;
                pix_b = r_pair.second_green;
            end
            pcdd_pkg::CH_BLUE: begin
                pix_a = r_pair.first_blue;
                pix_b = r_pair.second_blue;
            end
            default: begin
                pix_a = r_pair.first_depth;
                pix_b = r_pair.second_depth;
            end
        endcase
        abs_diff = (pix_a > pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
    end

    // The shared multiplier: squares, then the two weight products.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_SQ: begin
                mul_a = SUMC_W'(abs_diff);
                mul_b = pcdd_pkg::MULB_W'(abs_diff);
            end
            ST_WC: begin
                mul_a = r_color;
                mul_b = pcdd_pkg::MULB_W'(W'(pcdd_pkg::FULL_WEIGHT) - w_sat);
            end
            ST_WD: begin
                mul_a = SUMC_W'(r_depth);
                mul_b = pcdd_pkg::MULB_W'(w_sat) + pcdd_pkg::MULB_W'({w_sat, 1'b0});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign div_sub = {1'b0, r_rem} - {1'b0, r_dsor};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (takes) begin
                        n_state = ST_SQ;
                    end else if (i_in_data.last_pair) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_SQ: begin
                if (r_ch == pcdd_pkg::CH_DEPTH) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_state = r_last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                n_state = (r_count == '0) ? ST_EMIT : ST_WC;
            end
            ST_WC:  n_state = ST_WD;
            ST_WD:  n_state = ST_NUM;
            ST_NUM: n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_weight    <= W'(pcdd_pkg::WEIGHT_RESET);
            r_count     <= '0;
            r_color     <= '0;
            r_depth     <= '0;
            r_den       <= '0;
            r_acc_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc_en <= (r_state == ST_SQ);
            if (i_cfg_we) begin
                r_weight <= i_cfg_data;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (emit_fire) begin
                r_count <= '0;
                r_color <= '0;
                r_depth <= '0;
                r_den   <= '0;
            end else begin
                if (in_acc && takes) begin
                    r_count <= r_count + CNT_W'(1);
                    r_den   <= r_den + SUMC_W'(pcdd_pkg::COLOR_NORM);
                end
                // Each product is registered and reaches its sum in the cycle after its multiply.
                if (r_acc_en) begin
                    if (r_acc_ch == pcdd_pkg::CH_DEPTH) begin
                        r_depth <= r_depth + SUMD_W'(r_prod);
                    end else begin
                        r_color <= r_color + SUMC_W'(r_prod);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= mul_p;
        r_acc_ch <= r_ch;
        if (in_acc) begin
            r_pair <= i_in_data;
            r_last <= i_in_data.last_pair;
            r_ch   <= pcdd_pkg::CH_RED;
        end else if (r_state == ST_SQ) begin
            r_ch <= r_ch + 2'd1;
        end
        if (r_state == ST_WD) begin
            r_num <= NUMP_W'(r_prod);
        end
        if (r_state == ST_NUM) begin
            r_rem  <= {NUMP_W'(r_num + NUMP_W'(r_prod)), {pcdd_pkg::SCALE_SH{1'b0}}};
            r_dsor <= {r_den, {pcdd_pkg::FRAC_W{1'b0}}};
            r_quo  <= '0;
            r_step <= STEP_W'(pcdd_pkg::QUO_W - 1);
        end else if (r_state == ST_DIV) begin
            if (!div_sub[NUM_W]) begin
                r_rem <= div_sub[NUM_W-1:0];
            end
            r_quo  <= {r_quo[pcdd_pkg::QUO_W-2:0], ~div_sub[NUM_W]};
            r_dsor <= r_dsor >> 1;
            r_step <= r_step - STEP_W'(1);
        end
        if (emit_fire) begin
            if (r_count == '0) begin
                r_out_data.patch_cost     <= '0;
                r_out_data.no_valid_pairs <= 1'b1;
            end else begin
                r_out_data.patch_cost     <= r_quo[pcdd_pkg::QUO_W-1] ? '1
                                             : r_quo[pcdd_pkg::COST_W-1:0];
                r_out_data.no_valid_pairs <= 1'b0;
            end
            r_out_data.pairs_counted <= pcdd_pkg::PAIRS_W'(r_count);
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PAIRS))
        else $error("pair count above the patch limit");

    a_sums_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_color == '0 && r_depth == '0 && r_den == '0))
        else $error("sums not clear while no pair is counted");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> ({1'b0, r_rem} < {r_dsor, 1'b0}))
        else $error("divider remainder out of range");

    a_skip_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_data.pair_valid && !i_in_data.last_pair) |=> o_in_ready)
        else $error("ignored pair did not return to idle");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.no_valid_pairs) |->
            (o_out_data.patch_cost == '0 && o_out_data.pairs_counted == '0))
        else $error("empty result carries a cost or a count");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

// Testbench for the patch distance engine.
//
// Pixel pairs are offered on the input channel and results are taken from the output
// channel. Both sides use valid and ready, and each side idles or stalls at random
// between transactions. A predictor in this file keeps its own copy of the colour sum,
// the depth sum, the pair count and the depth weight. It works out the expected result
// for every pair that closes a patch. Results are checked field by field, in order,
// against the oldest outstanding expectation.
//
// The run has two parts. A short directed table comes first. It covers the state
// straight after reset, full-scale and zero costs at the weight extremes, a weight
// above 256, an empty patch, a half-scale cost and multi-pair patches. Random patches follow under
// several weight settings. One of these patches is at least as long as the pair
// limit.

module tb;

    // This margin covers the longest busy spell after the final pair of a patch, so
    // this leaves a comfortable margin before the weight is touched or the run ends.
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 50;

    // One row of the directed table. Where typed is set, want holds the result written
    // in by hand. Otherwise the predictor supplies the expectation.
    typedef struct {
        logic [pcdd_pkg::WEIGHT_W-1:0] weight;
        pcdd_pkg::t_pair               pair;
        bit                            typed;
        pcdd_pkg::t_result             want;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n   = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    pcdd_pkg::t_pair               in_pair   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    pcdd_pkg::t_result             out_res;
    logic                          cfg_we    = 1'b0;
    logic [pcdd_pkg::WEIGHT_W-1:0] cfg_data  = '0;

    // The predictor's copy of the block state and of the weight register.
    logic [27:0]                   colour_acc = '0;
    logic [25:0]                   depth_acc  = '0;
    logic [pcdd_pkg::PAIRS_W-1:0]  pairs_acc  = '0;
    logic [pcdd_pkg::WEIGHT_W-1:0] weight_reg =
        pcdd_pkg::WEIGHT_W'(pcdd_pkg::WEIGHT_RESET);

    pcdd_pkg::t_result             cost_expected[$];
    t_row                          rows[$];
    int unsigned                   mismatches  = 0;
    // While this is set, neither side idles, so the block sees back-to-back traffic.
    bit                            steady_flow = 1'b0;

    patch_color_depth_distance u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_pair),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Reset is held at the start and then released on a falling edge, once only.
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // This is a watchdog. A correct run finishes in a small fraction of this time.
    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [17:0] sq_diff(input logic [pcdd_pkg::PIX_W-1:0] a,
                                            input logic [pcdd_pkg::PIX_W-1:0] b);
        logic [pcdd_pkg::PIX_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return 18'(d) * 18'(d);
    endfunction

    // This accumulates one pair into the predicted state. When the pair closes a
    // patch, it returns 1 with the expected result in r and clears the sums.
    function automatic bit predict_patch_cost(input pcdd_pkg::t_pair p,
                                              output pcdd_pkg::t_result r);
        longint unsigned w;
        longint unsigned num;
        longint unsigned den;
        longint unsigned quo;
        r = '0;
        if (p.pair_valid &&
            pairs_acc < pcdd_pkg::PAIRS_W'(pcdd_pkg::MAX_PAIRS_DEF)) begin
            colour_acc += 28'(sq_diff(p.first_red, p.second_red))
                        + 28'(sq_diff(p.first_green, p.second_green))
                        + 28'(sq_diff(p.first_blue, p.second_blue));
            depth_acc  += 26'(sq_diff(p.first_depth, p.second_depth));
            pairs_acc  += pcdd_pkg::PAIRS_W'(1);
        end
        if (!p.last_pair) begin
            return 1'b0;
        end
        if (pairs_acc == 0) begin
            r.no_valid_pairs = 1'b1;
        end else begin
            // A weight above full scale counts as full scale, so the cost is depth only.
            w   = (weight_reg > pcdd_pkg::WEIGHT_W'(pcdd_pkg::FULL_WEIGHT)) ?
                  64'(pcdd_pkg::FULL_WEIGHT) : 64'(weight_reg);
            num = 64'd256 * ((64'(pcdd_pkg::FULL_WEIGHT) - w) * 64'(colour_acc)
                             + 64'd3 * w * 64'(depth_acc));
            den = 64'(pcdd_pkg::COLOR_NORM) * 64'(pairs_acc);
            quo = num / den;
            // A cost of exactly 1.0 does not fit in Q0.16 and saturates.
            r.patch_cost    = (quo > 64'd65535) ? 16'hFFFF : quo[15:0];
            r.pairs_counted = pairs_acc;
        end
        colour_acc = '0;
        depth_acc  = '0;
        pairs_acc  = '0;
        return 1'b1;
    endfunction

    function automatic int unsigned idle_gap();
        return steady_flow ? 0 : $urandom_range(0, 4);
    endfunction

    // Channel values lean towards the extremes now and then, so that the largest
    // squared differences turn up often.
    function automatic logic [pcdd_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return pcdd_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pcdd_pkg::t_pair random_pair(input bit valid, input bit last);
        pcdd_pkg::t_pair p;
        p.first_red    = random_pixel();
        p.first_green  = random_pixel();
        p.first_blue   = random_pixel();
        p.first_depth  = random_pixel();
        p.second_red   = random_pixel();
        p.second_green = random_pixel();
        p.second_blue  = random_pixel();
        p.second_depth = random_pixel();
        p.pair_valid   = valid;
        p.last_pair    = last;
        return p;
    endfunction

    task automatic add_row(input logic [pcdd_pkg::WEIGHT_W-1:0] w,
                           input pcdd_pkg::t_pair p, input bit typed,
                           input pcdd_pkg::t_result r);
        rows.push_back(t_row'{w, p, typed, r});
    endtask

    // This offers one pair after a random gap and waits for the transaction. The new
    // payload goes out on a falling edge. Valid is lowered on an earlier falling edge
    // only when there is a gap, so no signal gets two assignments in one step.
    task automatic send_pair(input pcdd_pkg::t_pair p, input bit typed,
                             input pcdd_pkg::t_result want);
        int unsigned       gap;
        pcdd_pkg::t_result r;
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_pair  <= p;
        do @(posedge i_clk); while (!in_ready);
        if (predict_patch_cost(p, r)) begin
            cost_expected.push_back(typed ? want : r);
        end
    endtask

    // This lets the block drain: every outstanding result has been taken, and then a
    // few further cycles pass in case the sequencer is still winding down.
    task automatic settle_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (cost_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [pcdd_pkg::WEIGHT_W-1:0] w);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= w;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        weight_reg = w;
    endtask

    // This is the result side. It stalls for a random number of cycles before each
    // transaction and then holds ready high until a result is taken.
    initial begin
        int unsigned       gap;
        pcdd_pkg::t_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = idle_gap();
            @(negedge i_clk);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            if (cost_expected.size() == 0) begin
                $error("result with no patch outstanding: patch_cost %0d, pairs_counted %0d",
                       out_res.patch_cost, out_res.pairs_counted);
                mismatches++;
            end else begin
                want = cost_expected.pop_front();
                if (out_res.patch_cost !== want.patch_cost) begin
                    $error("patch_cost: expected %0d, got %0d",
                           want.patch_cost, out_res.patch_cost);
                    mismatches++;
                end
                if (out_res.pairs_counted !== want.pairs_counted) begin
                    $error("pairs_counted: expected %0d, got %0d",
                           want.pairs_counted, out_res.pairs_counted);
                    mismatches++;
                end
                if (out_res.no_valid_pairs !== want.no_valid_pairs) begin
                    $error("no_valid_pairs: expected %0d, got %0d",
                           want.no_valid_pairs, out_res.no_valid_pairs);
                    mismatches++;
                end
            end
        end
    end

    // This is the pair side: the directed table first, then the random phases.
    initial begin
        t_row                          row;
        logic [pcdd_pkg::WEIGHT_W-1:0] nw;
        int unsigned                   n;
        int unsigned                   len;
        int unsigned                   phase_items;
        bit                            dead;

        // The first rows run at the reset weight, which is not written beforehand.
        // A patch with nothing valid comes out empty with a zero cost.
        add_row(9'd51,
                pcdd_pkg::t_pair'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                  1'b0, 1'b1},
                1, pcdd_pkg::t_result'{16'h0000, 11'd0, 1'b1});
        // Identical pixels give zero cost, but the pair is still counted.
        add_row(9'd51,
                pcdd_pkg::t_pair'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                  1'b1, 1'b1},
                1, pcdd_pkg::t_result'{16'h0000, 11'd1, 1'b0});
        // With the largest difference on every channel, the cost is 1.0 for any weight.
        add_row(9'd51,
                pcdd_pkg::t_pair'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                                  1'b1, 1'b1},
                1, pcdd_pkg::t_result'{16'hFFFF, 11'd1, 1'b0});
        // At weight zero only colour matters.
        add_row(9'd0,
                pcdd_pkg::t_pair'{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h00, 8'h80,
                                  1'b1, 1'b1},
                1, pcdd_pkg::t_result'{16'hFFFF, 11'd1, 1'b0});
        add_row(9'd0,
                pcdd_pkg::t_pair'{8'h12, 8'h12, 8'h12, 8'h00, 8'h12, 8'h12, 8'h12, 8'hFF,
                                  1'b1, 1'b1},
                1, pcdd_pkg::t_result'{16'h0000, 11'd1, 1'b0});
        // At full weight only depth matters.
        add_row(9'd256,
                pcdd_pkg::t_pair'{8'h34, 8'h56, 8'h78, 8'hFF, 8'h34, 8'h56, 8'h78, 8'h00,
                                  1'b1, 1'b1},
                1, pcdd_pkg::t_result'{16'hFFFF, 11'd1, 1'b0});
        add_row(9'd256,
                pcdd_pkg::t_pair'{8'h00, 8'h00, 8'h00, 8'h9A, 8'hFF, 8'hFF, 8'hFF, 8'h9A,
                                  1'b1, 1'b1},
                1, pcdd_pkg::t_result'{16'h0000, 11'd1, 1'b0});
        // A weight above full scale behaves like full scale.
        add_row(9'd511,
                pcdd_pkg::t_pair'{8'hFF, 8'hFF, 8'hFF, 8'h40, 8'h00, 8'h00, 8'h00, 8'h40,
                                  1'b1, 1'b1},
                1, pcdd_pkg::t_result'{16'h0000, 11'd1, 1'b0});
        add_row(9'd511,
                pcdd_pkg::t_pair'{8'h21, 8'h43, 8'h65, 8'h00, 8'h21, 8'h43, 8'h65, 8'hFF,
                                  1'b1, 1'b1},
                1, pcdd_pkg::t_result'{16'hFFFF, 11'd1, 1'b0});
        // An out-of-bounds pair is ignored even when its pixels differ.
        add_row(9'd511,
                pcdd_pkg::t_pair'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                                  1'b0, 1'b1},
                1, pcdd_pkg::t_result'{16'h0000, 11'd0, 1'b1});
        // Equal colour and depth weights with full colour error give exactly one half.
        add_row(9'd128,
                pcdd_pkg::t_pair'{8'h00, 8'hFF, 8'h00, 8'h77, 8'hFF, 8'h00, 8'hFF, 8'h77,
                                  1'b1, 1'b1},
                1, pcdd_pkg::t_result'{16'h8000, 11'd1, 1'b0});
        // The remaining rows form patches of one or more pairs, some mixing valid and
        // out-of-bounds pairs. The predictor supplies their expected results.
        add_row(9'd51,
                pcdd_pkg::t_pair'{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0,
                                  1'b1, 1'b0}, 0, '0);
        add_row(9'd51,
                pcdd_pkg::t_pair'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                                  1'b0, 1'b0}, 0, '0);
        add_row(9'd51,
                pcdd_pkg::t_pair'{8'h01, 8'h80, 8'h7F, 8'hFE, 8'h02, 8'h7F, 8'h80, 8'h01,
                                  1'b1, 1'b0}, 0, '0);
        add_row(9'd51,
                pcdd_pkg::t_pair'{8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA,
                                  1'b0, 1'b1}, 0, '0);
        add_row(9'd128,
                pcdd_pkg::t_pair'{8'h55, 8'h55, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA, 8'hAA,
                                  1'b1, 1'b0}, 0, '0);
        add_row(9'd128,
                pcdd_pkg::t_pair'{8'hAA, 8'h0F, 8'hF0, 8'h33, 8'h55, 8'hF0, 8'h0F, 8'hCC,
                                  1'b1, 1'b0}, 0, '0);
        add_row(9'd128,
                pcdd_pkg::t_pair'{8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'hF0, 8'hF0, 8'hF0, 8'hF0,
                                  1'b1, 1'b1}, 0, '0);
        add_row(9'd1,
                pcdd_pkg::t_pair'{8'h10, 8'h20, 8'h30, 8'h00, 8'h90, 8'hA0, 8'hB0, 8'h01,
                                  1'b1, 1'b1}, 0, '0);
        add_row(9'd255,
                pcdd_pkg::t_pair'{8'h3C, 8'hC3, 8'h5A, 8'hA5, 8'hC3, 8'h3C, 8'hA5, 8'h5A,
                                  1'b1, 1'b1}, 0, '0);

        wait (i_rst_n === 1'b1);

        // The weight is only rewritten between patches, once the block has drained.
        foreach (rows[i]) begin
            row = rows[i];
            if (row.weight != weight_reg) begin
                settle_idle();
                write_weight(row.weight);
            end
            send_pair(row.pair, row.typed, row.want);
        end

        // Each random phase runs under one weight setting. The first six phases cover
        // the extremes and a few notable values, and the rest draw a random weight.
        // Every third phase runs without idling on either side.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: nw = 9'd0;
                1: nw = 9'd256;
                2: nw = 9'd511;
                3: nw = 9'd51;
                4: nw = 9'd1;
                5: nw = 9'd255;
                default: nw = pcdd_pkg::WEIGHT_W'($urandom_range(0, 511));
            endcase
            settle_idle();
            write_weight(nw);
            steady_flow = (ph % 3 == 1);

            // In one phase one patch is at least as long as the pair limit. Pairs
            // beyond the limit must not reach the sums or the count.
            if (ph == 2) begin
                n = pcdd_pkg::MAX_PAIRS_DEF + $urandom_range(0, 8);
                for (int unsigned i = 0; i < n; i++) begin
                    send_pair(random_pair(1'b1, i == n - 1), 0, '0);
                end
            end

            // Most patches are short and mostly valid. Now and then a patch has no
            // valid pair at all.
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                len  = $urandom_range(1, 12);
                dead = ($urandom_range(0, 14) == 0);
                for (int unsigned i = 0; i < len; i++) begin
                    send_pair(random_pair(!dead && ($urandom_range(0, 9) != 0),
                                          i == len - 1), 0, '0);
                    phase_items++;
                end
            end
        end

        steady_flow = 1'b0;
        settle_idle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
